FILE: src/magnetometer_iron_calibration_defines.svh
// ---------------------------------------------------------------------------
// Magnetometer iron calibration assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during reset.
// ---------------------------------------------------------------------------
`ifndef MAGNETOMETER_IRON_CALIBRATION_DEFINES_SVH
`define MAGNETOMETER_IRON_CALIBRATION_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MAGCAL_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MAGCAL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/magcal_pkg.sv
// ---------------------------------------------------------------------------
// Magnetometer iron calibration package
// Widths, register indexes and reset values shared by the calibration block.
// ---------------------------------------------------------------------------
`default_nettype none

package magcal_pkg;

  localparam int RAW_W    = 16;
  localparam int COEF_W   = 16;
  localparam int DIFF_W   = 18;
  localparam int PROD_W   = COEF_W + DIFF_W;
  localparam int ACC_W    = PROD_W + 2;
  localparam int FIELD_W  = 24;
  localparam int REG_W    = 48;
  localparam int PDATA_W  = 64;
  localparam int PADDR_W  = 5;

  typedef enum logic [1:0] {
    REG_ROW_X   = 2'd0,
    REG_ROW_Y   = 2'd1,
    REG_ROW_Z   = 2'd2,
    REG_OFFSETS = 2'd3
  } reg_idx_t;

  localparam logic [REG_W-1:0] ROW_X_RST   = 48'h0000_0000_4000;
  localparam logic [REG_W-1:0] ROW_Y_RST   = 48'h0000_4000_0000;
  localparam logic [REG_W-1:0] ROW_Z_RST   = 48'h4000_0000_0000;
  localparam logic [REG_W-1:0] OFFSETS_RST = 48'h0000_0000_0000;

  typedef struct packed {
    logic signed [DIFF_W-1:0] z;
    logic signed [DIFF_W-1:0] y;
    logic signed [DIFF_W-1:0] x;
  } diff_t;

endpackage

`default_nettype wire

FILE: src/magcal_if.sv
// ---------------------------------------------------------------------------
// Magnetometer iron calibration channels
// Valid/ready channels for raw samples and calibrated results.
// ---------------------------------------------------------------------------
`default_nettype none

interface magcal_in_if;
  import magcal_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [RAW_W-1:0] raw_x;
  logic signed [RAW_W-1:0] raw_y;
  logic signed [RAW_W-1:0] raw_z;
  logic                    read_ok;

  modport source (output valid, raw_x, raw_y, raw_z, read_ok, input ready);
  modport sink   (input valid, raw_x, raw_y, raw_z, read_ok, output ready);
endinterface

interface magcal_out_if;
  import magcal_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] field_x;
  logic signed [FIELD_W-1:0] field_y;
  logic signed [FIELD_W-1:0] field_z;
  logic                      valid_res;

  modport source (output valid, field_x, field_y, field_z, valid_res, input ready);
  modport sink   (input valid, field_x, field_y, field_z, valid_res, output ready);
endinterface

`default_nettype wire

FILE: src/magcal_row.sv
// ---------------------------------------------------------------------------
// Magnetometer iron calibration row
// One matrix row: three registered products, a registered sum, then a floor
// shift with saturation to the output width.
// ---------------------------------------------------------------------------
`default_nettype none

module magcal_row #(
  parameter int COEF_FRAC_BITS = 14
) (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic [magcal_pkg::REG_W-1:0]          row,
  input  magcal_pkg::diff_t                     diff,
  output logic signed [magcal_pkg::FIELD_W-1:0] field
);
  import magcal_pkg::*;

  logic signed [PROD_W-1:0] px_r, py_r, pz_r;
  logic signed [PROD_W-1:0] px_nxt, py_nxt, pz_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [ACC_W-1:0]  shifted;
  logic                     ovf;

  assign px_nxt = $signed(row[COEF_W-1:0])          * diff.x;
  assign py_nxt = $signed(row[2*COEF_W-1:COEF_W])   * diff.y;
  assign pz_nxt = $signed(row[3*COEF_W-1:2*COEF_W]) * diff.z;

  assign acc_nxt = ACC_W'(px_r) + ACC_W'(py_r) + ACC_W'(pz_r);

  always_ff @(posedge clk) begin
    if (en) begin
      px_r  <= px_nxt;
      py_r  <= py_nxt;
      pz_r  <= pz_nxt;
      acc_r <= acc_nxt;
    end
  end

  // Arithmetic shift rounds toward minus infinity. The result fits when all
  // bits above the output sign bit agree with it.
  assign shifted = acc_r >>> COEF_FRAC_BITS;
  assign ovf = !((&shifted[ACC_W-1:FIELD_W-1]) || !(|shifted[ACC_W-1:FIELD_W-1]));

  always_comb begin
    if (ovf) begin
      field = shifted[ACC_W-1] ? {1'b1, {(FIELD_W-1){1'b0}}} : {1'b0, {(FIELD_W-1){1'b1}}};
    end else begin
      field = shifted[FIELD_W-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: src/magnetometer_iron_calibration.sv
// ---------------------------------------------------------------------------
// Magnetometer hard/soft-iron calibration
// Removes the hard-iron offset from each raw sample and applies the 3x3
// soft-iron matrix, one sample per clock unless the output stalls.
// ---------------------------------------------------------------------------
// The block takes one raw sample per clock and returns one result per sample
// in the same order. On its way to the output channel a sample passes the
// offset subtraction, registered at the accepting edge, then the registered
// products of the nine multipliers, the three row sums and the output
// register, each one more stage. Throughput is one transfer per
// cycle on each side. When the output holds a result that the consumer does
// not take, the whole pipeline freezes and the input stops accepting; nothing
// is dropped or repeated. A failed bus read travels through the pipeline and
// comes out with valid_res low and all fields zero. Registers are 48 bits
// wide at 8-byte spacing on a 64-bit APB data bus; write them only while no
// sample is in flight.
`default_nettype none
`include "magnetometer_iron_calibration_defines.svh"

module magnetometer_iron_calibration #(
  parameter int COEF_FRAC_BITS = 14
) (
  input  logic                             clk,
  input  logic                             rst_n,
  magcal_in_if.sink                        in_ch,
  magcal_out_if.source                     out_ch,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [magcal_pkg::PADDR_W-1:0]   paddr,
  input  logic [magcal_pkg::PDATA_W-1:0]   pwdata,
  output logic [magcal_pkg::PDATA_W-1:0]   prdata,
  output logic                             pready
);
  import magcal_pkg::*;

  // Configuration registers.
  logic [REG_W-1:0] row_x_r, row_y_r, row_z_r, offsets_r;
  reg_idx_t         reg_idx;
  logic             cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:3]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_x_r   <= ROW_X_RST;
      row_y_r   <= ROW_Y_RST;
      row_z_r   <= ROW_Z_RST;
      offsets_r <= OFFSETS_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_ROW_X:   row_x_r   <= pwdata[REG_W-1:0];
        REG_ROW_Y:   row_y_r   <= pwdata[REG_W-1:0];
        REG_ROW_Z:   row_z_r   <= pwdata[REG_W-1:0];
        REG_OFFSETS: offsets_r <= pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ROW_X:   prdata = PDATA_W'(row_x_r);
      REG_ROW_Y:   prdata = PDATA_W'(row_y_r);
      REG_ROW_Z:   prdata = PDATA_W'(row_z_r);
      REG_OFFSETS: prdata = PDATA_W'(offsets_r);
      default:     prdata = '0;
    endcase
  end

  // The pipeline moves as one: every stage advances whenever the output
  // register is empty or its result is being transferred out.
  logic out_v_r;
  logic adv;

  assign adv         = !out_v_r || out_ch.ready;
  assign in_ch.ready = adv;

  // Stage 1: orientation flip and hard-iron offset removal. The difference
  // needs 18 bits because negating a raw count and then subtracting an offset
  // can reach +65536 (the low end is -65534).
  logic signed [DIFF_W-1:0] rx_e, ry_e, rz_e, ox_e, oy_e, oz_e;
  diff_t                    d1_nxt, d1_r;
  logic                     s1_v_r, s1_ok_r;

  assign rx_e = DIFF_W'(in_ch.raw_x);
  assign ry_e = DIFF_W'(in_ch.raw_y);
  assign rz_e = DIFF_W'(in_ch.raw_z);
  assign ox_e = DIFF_W'($signed(offsets_r[RAW_W-1:0]));
  assign oy_e = DIFF_W'($signed(offsets_r[2*RAW_W-1:RAW_W]));
  assign oz_e = DIFF_W'($signed(offsets_r[3*RAW_W-1:2*RAW_W]));

  assign d1_nxt.x = -rx_e - ox_e;
  assign d1_nxt.y = ry_e - oy_e;
  assign d1_nxt.z = rz_e - oz_e;

  always_ff @(posedge clk) begin
    if (adv) begin
      d1_r <= d1_nxt;
    end
  end

  // Stages 2 and 3 live in the row units: products, then row sums.
  logic signed [FIELD_W-1:0] fx, fy, fz;

  magcal_row #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_row_x (
    .clk(clk), .en(adv), .row(row_x_r), .diff(d1_r), .field(fx)
  );
  magcal_row #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_row_y (
    .clk(clk), .en(adv), .row(row_y_r), .diff(d1_r), .field(fy)
  );
  magcal_row #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_row_z (
    .clk(clk), .en(adv), .row(row_z_r), .diff(d1_r), .field(fz)
  );

  // Valid and read status bits ride alongside the data.
  logic s2_v_r, s2_ok_r, s3_v_r, s3_ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r  <= in_ch.valid;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      out_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ok_r <= in_ch.read_ok;
      s2_ok_r <= s1_ok_r;
      s3_ok_r <= s2_ok_r;
    end
  end

  // Stage 4: output register. A failed read reports zero fields.
  logic signed [FIELD_W-1:0] fx_r, fy_r, fz_r;
  logic                      vres_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      fx_r   <= s3_ok_r ? fx : '0;
      fy_r   <= s3_ok_r ? fy : '0;
      fz_r   <= s3_ok_r ? fz : '0;
      vres_r <= s3_ok_r;
    end
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.field_x   = fx_r;
  assign out_ch.field_y   = fy_r;
  assign out_ch.field_z   = fz_r;
  assign out_ch.valid_res = vres_r;

  // A result marked invalid must carry zero fields.
  `MAGCAL_ASSERT_SAME(a_fail_zero, out_v_r && !vres_r, fx_r == '0 && fy_r == '0 && fz_r == '0, "failed read result has nonzero fields")
  // A stalled output freezes every stage's valid bit.
  `MAGCAL_ASSERT_NEXT(a_stall_freeze, out_v_r && !out_ch.ready, $stable(s1_v_r) && $stable(s2_v_r) && $stable(s3_v_r) && $stable(out_v_r), "pipeline moved during a stall")
  // An accepted sample lands in stage 1 with its read status.
  `MAGCAL_ASSERT_NEXT(a_accept_s1, in_ch.valid && in_ch.ready, s1_v_r && s1_ok_r == $past(in_ch.read_ok), "accepted sample missing from stage 1")

endmodule

`default_nettype wire

FILE: bench/magnetometer_iron_calibration_test.sv
// ----------------------------------------------------------------------------
// Magnetometer iron calibration testbench
// Drives raw samples through the calibration block under several matrix and
// offset settings and checks every result against a local model or a table.
// ----------------------------------------------------------------------------
module magnetometer_iron_calibration_test;
  timeunit 1ns;
  timeprecision 1ps;

  import magcal_pkg::*;

  // Fraction bits of the soft-iron coefficients, shared with the block.
  localparam int FRAC = 14;
  localparam longint OUT_MAX = 64'sd8388607;
  localparam longint OUT_MIN = -64'sd8388608;
  // A run that sees no transfer for this many cycles is declared hung.
  localparam int unsigned HANG_LIMIT = 2000;
  // Cycles of output hold-off used to fill the pipeline and stall the input.
  localparam int unsigned LONG_HOLD = 64;
  // Cycles to wait after the last result for anything unexpected to appear.
  localparam int unsigned TAIL_CYCLES = 8;
  localparam int unsigned PHASE_ITEMS = 80;
  localparam int unsigned RANDOM_PHASES = 5;
  localparam int unsigned TABLE_ROWS = 12;

  typedef struct packed {
    logic signed [RAW_W-1:0] raw_x;
    logic signed [RAW_W-1:0] raw_y;
    logic signed [RAW_W-1:0] raw_z;
    logic                    read_ok;
  } sample_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] field_x;
    logic signed [FIELD_W-1:0] field_y;
    logic signed [FIELD_W-1:0] field_z;
    logic                      valid_res;
  } field_t;

  // One row of the directed table. When typed is set, want holds the result
  // read straight off the identity setting; otherwise the model decides.
  typedef struct packed {
    sample_t smp;
    bit      typed;
    field_t  want;
  } table_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  magcal_in_if  in_ch();
  magcal_out_if out_ch();

  magnetometer_iron_calibration #(
    .COEF_FRAC_BITS(FRAC)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Our copy of the calibration registers, updated on every write.
  logic [REG_W-1:0] row_x_coef = ROW_X_RST;
  logic [REG_W-1:0] row_y_coef = ROW_Y_RST;
  logic [REG_W-1:0] row_z_coef = ROW_Z_RST;
  logic [REG_W-1:0] hard_offsets = OFFSETS_RST;

  // Calibrated fields still owed by the block, oldest first.
  field_t pending_fields [$];

  int unsigned samples_sent = 0;
  int unsigned results_checked = 0;
  int unsigned failed_reads_sent = 0;
  int unsigned input_stalls = 0;
  int unsigned mismatch_count = 0;

  // Set by the stimulus to run a phase with no idling on either side.
  bit idle_free = 1'b0;
  bit long_hold_req = 1'b0;

  table_row_t directed_rows [TABLE_ROWS];

  // ---------------------------------------------------------------------------
  // Calibration model
  // ---------------------------------------------------------------------------

  // Signed 16-bit lane idx of a packed three-lane register.
  function automatic longint coef_lane(logic [REG_W-1:0] word, int idx);
    logic signed [15:0] v;
    v = word[16*idx +: 16];
    return longint'(v);
  endfunction

  // One output axis: the dot product of a matrix row with the offset-corrected
  // vector, floored by the fraction shift and clamped to 24 bits.
  function automatic logic signed [FIELD_W-1:0] row_field(logic [REG_W-1:0] row,
                                                          longint dx, longint dy,
                                                          longint dz);
    longint acc;
    acc = coef_lane(row, 0) * dx + coef_lane(row, 1) * dy + coef_lane(row, 2) * dz;
    // An arithmetic shift of a signed value rounds toward minus infinity.
    acc = acc >>> FRAC;
    if (acc > OUT_MAX) acc = OUT_MAX;
    if (acc < OUT_MIN) acc = OUT_MIN;
    return acc[FIELD_W-1:0];
  endfunction

  function automatic field_t calibrate(sample_t s);
    field_t r;
    longint dx;
    longint dy;
    longint dz;
    r = '0;
    // A failed bus read yields an empty result with all fields at zero.
    if (!s.read_ok) return r;
    // X is mirrored by the mounting, so it is negated before the offset; the
    // difference needs 18 bits at the extremes and is kept exact here.
    dx = -longint'(s.raw_x) - coef_lane(hard_offsets, 0);
    dy = longint'(s.raw_y) - coef_lane(hard_offsets, 1);
    dz = longint'(s.raw_z) - coef_lane(hard_offsets, 2);
    r.field_x = row_field(row_x_coef, dx, dy, dz);
    r.field_y = row_field(row_y_coef, dx, dy, dz);
    r.field_z = row_field(row_z_coef, dx, dy, dz);
    r.valid_res = 1'b1;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Random choices
  // ---------------------------------------------------------------------------

  // Idle length: usually none, often a few cycles, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Raw counts lean on the range ends, zero and minus one now and then, otherwise uniform.
  function automatic logic signed [RAW_W-1:0] pick_raw();
    case ($urandom_range(0, 19))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'sh0000;
      3: return 16'shFFFF;
      default: return RAW_W'($urandom);
    endcase
  endfunction

  function automatic sample_t pick_sample();
    sample_t s;
    s.raw_x = pick_raw();
    s.raw_y = pick_raw();
    s.raw_z = pick_raw();
    s.read_ok = ($urandom_range(0, 99) < 88);
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration port. Every task starts and ends just after a rising edge,
  // and drops psel before its final edge so back-to-back calls never raise and
  // lower psel in the same step.
  // ---------------------------------------------------------------------------

  task automatic write_reg(input reg_idx_t idx, input logic [REG_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_ROW_X:   row_x_coef = value;
      REG_ROW_Y:   row_y_coef = value;
      REG_ROW_Z:   row_z_coef = value;
      REG_OFFSETS: hard_offsets = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic check_reg(input reg_idx_t idx, input logic [REG_W-1:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 3'b000};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[REG_W-1:0] !== want) begin
      $error("%s readback: expected %h, got %h", idx.name(), want, prdata[REG_W-1:0]);
      mismatch_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Writes the full matrix and offsets, then reads all four back.
  task automatic load_settings(input logic [REG_W-1:0] rx, input logic [REG_W-1:0] ry,
                               input logic [REG_W-1:0] rz, input logic [REG_W-1:0] offs);
    write_reg(REG_ROW_X, rx);
    write_reg(REG_ROW_Y, ry);
    write_reg(REG_ROW_Z, rz);
    write_reg(REG_OFFSETS, offs);
    check_reg(REG_ROW_X, rx);
    check_reg(REG_ROW_Y, ry);
    check_reg(REG_ROW_Z, rz);
    check_reg(REG_OFFSETS, offs);
  endtask

  // ---------------------------------------------------------------------------
  // Sample side
  // ---------------------------------------------------------------------------

  // Offers one sample and holds it until the block takes it. The expected
  // result is queued at the edge of the transfer.
  task automatic offer_sample(input sample_t s, input bit typed, input field_t want);
    in_ch.valid   <= 1'b1;
    in_ch.raw_x   <= s.raw_x;
    in_ch.raw_y   <= s.raw_y;
    in_ch.raw_z   <= s.raw_z;
    in_ch.read_ok <= s.read_ok;
    do @(posedge clk); while (!in_ch.ready);
    pending_fields.push_back(typed ? want : calibrate(s));
    samples_sent++;
    if (!s.read_ok) failed_reads_sent++;
  endtask

  task automatic sender_pause();
    int unsigned gap;
    gap = idle_free ? 0 : pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Ends a phase: stop offering and wait until every result has come back.
  // Each sample yields exactly one result, so an empty queue means idle.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_fields.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: the receiver stalls at random, and on request holds off for
  // a long stretch that it counts down itself, so the pipeline backs up.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end else if (hold_left == 0 && !idle_free) begin
        hold_left = pick_gap();
      end
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Every result transfer is compared with the oldest expected result.
  always @(posedge clk) begin
    field_t exp_f;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_fields.size() == 0) begin
        $error("result with no sample outstanding: %0d %0d %0d valid_res=%0b",
               out_ch.field_x, out_ch.field_y, out_ch.field_z, out_ch.valid_res);
        mismatch_count++;
      end else begin
        exp_f = pending_fields.pop_front();
        results_checked++;
        if (out_ch.field_x !== exp_f.field_x) begin
          $error("field_x: expected %0d, got %0d", exp_f.field_x, out_ch.field_x);
          mismatch_count++;
        end
        if (out_ch.field_y !== exp_f.field_y) begin
          $error("field_y: expected %0d, got %0d", exp_f.field_y, out_ch.field_y);
          mismatch_count++;
        end
        if (out_ch.field_z !== exp_f.field_z) begin
          $error("field_z: expected %0d, got %0d", exp_f.field_z, out_ch.field_z);
          mismatch_count++;
        end
        if (out_ch.valid_res !== exp_f.valid_res) begin
          $error("valid_res: expected %0b, got %0b", exp_f.valid_res, out_ch.valid_res);
          mismatch_count++;
        end
      end
    end
  end

  // Hang detector: counts cycles in which nothing moves on any port, and tallies input stalls.
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < HANG_LIMIT) begin
      @(posedge clk);
      if (in_ch.valid && !in_ch.ready) input_stalls++;
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel || !rst_n)
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $error("no transfer for %0d cycles, %0d results outstanding", HANG_LIMIT,
           pending_fields.size());
    $display("FAIL magnetometer_iron_calibration");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    sample_t s;
    table_row_t row;
    field_t none;

    none = '0;
    in_ch.valid   <= 1'b0;
    in_ch.raw_x   <= '0;
    in_ch.raw_y   <= '0;
    in_ch.raw_z   <= '0;
    in_ch.read_ok <= 1'b0;

    // Directed samples. Under the reset setting the matrix is the identity and
    // the offsets are zero, so a good read comes back as (-x, y, z).
    directed_rows = '{
      '{'{16'sd0, 16'sd0, 16'sd0, 1'b1}, 1'b1, '{24'sd0, 24'sd0, 24'sd0, 1'b1}},
      '{'{16'sd32767, 16'sd32767, 16'sd32767, 1'b1}, 1'b1,
        '{-24'sd32767, 24'sd32767, 24'sd32767, 1'b1}},
      // Negating the most negative X count needs one bit beyond 16.
      '{'{-16'sd32768, -16'sd32768, -16'sd32768, 1'b1}, 1'b1,
        '{24'sd32768, -24'sd32768, -24'sd32768, 1'b1}},
      // Failed reads carry data that must not leak into the result.
      '{'{16'sd32767, 16'sd32767, 16'sd32767, 1'b0}, 1'b1, '{24'sd0, 24'sd0, 24'sd0, 1'b0}},
      '{'{-16'sd32768, -16'sd32768, -16'sd32768, 1'b0}, 1'b1,
        '{24'sd0, 24'sd0, 24'sd0, 1'b0}},
      '{'{16'sd1, -16'sd1, 16'sd1, 1'b1}, 1'b1, '{-24'sd1, -24'sd1, 24'sd1, 1'b1}},
      '{'{-16'sd1, -16'sd1, -16'sd1, 1'b1}, 1'b1, '{24'sd1, -24'sd1, -24'sd1, 1'b1}},
      '{'{16'sh5555, 16'shAAAA, 16'sh0F0F, 1'b1}, 1'b0, none},
      '{'{16'shAAAA, 16'sh5555, 16'shF0F0, 1'b1}, 1'b0, none},
      '{'{16'sd12345, -16'sd6789, 16'sd100, 1'b1}, 1'b0, none},
      '{'{-16'sd32768, 16'sd32767, -16'sd32768, 1'b1}, 1'b0, none},
      '{'{16'sd3, -16'sd3, 16'sd7, 1'b0}, 1'b0, none}
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Every register must come out of reset at its documented value.
    check_reg(REG_ROW_X, ROW_X_RST);
    check_reg(REG_ROW_Y, ROW_Y_RST);
    check_reg(REG_ROW_Z, ROW_Z_RST);
    check_reg(REG_OFFSETS, OFFSETS_RST);

    // The table runs twice: first on the identity, then on a setting with
    // extreme coefficients and offsets. The second pass drives X to the
    // 18-bit end of the difference range and uses a row of tiny coefficients
    // whose sums are mostly fractional, so negative results exercise the
    // rounding toward minus infinity.
    for (int pass = 0; pass < 2; pass++) begin
      if (pass == 1)
        load_settings(48'h8000_8000_8000, 48'h0001_0001_0001,
                      48'h4000_FFFF_7FFF, 48'h8000_7FFF_8000);
      foreach (directed_rows[i]) begin
        row = directed_rows[i];
        offer_sample(row.smp, row.typed && pass == 0, row.want);
        sender_pause();
      end
      drain_results();
    end

    // Random phases, each under its own setting. The first two pin the
    // coefficients and offsets to opposite range ends, the rest use random
    // register contents, and the third runs with no idling on either side.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: load_settings(48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF,
                         48'h7FFF_7FFF_7FFF, 48'h8000_8000_8000);
        1: load_settings(48'h8000_8000_8000, 48'h8000_8000_8000,
                         48'h8000_8000_8000, 48'h7FFF_7FFF_7FFF);
        default: load_settings(REG_W'({$urandom, $urandom}), REG_W'({$urandom, $urandom}),
                               REG_W'({$urandom, $urandom}), REG_W'({$urandom, $urandom}));
      endcase
      idle_free = (ph == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Early in the first phase the receiver goes quiet for a long stretch
        // while samples keep coming, so the block must stall its input.
        if (ph == 0 && n == 20) long_hold_req = 1'b1;
        s = pick_sample();
        offer_sample(s, 1'b0, none);
        sender_pause();
      end
      drain_results();
    end
    idle_free = 1'b0;

    // Anything the block still sends from here on is unexpected.
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d samples (%0d failed reads) over %0d register settings,",
             samples_sent, failed_reads_sent, RANDOM_PHASES + 2);
    $display("%0d results checked, %0d cycles with the input held off.",
             results_checked, input_stalls);
    if (mismatch_count == 0 && pending_fields.size() == 0) begin
      $display("PASS magnetometer_iron_calibration");
    end else begin
      $display("FAIL magnetometer_iron_calibration");
    end
    $finish;
  end

endmodule
